// File: rtl/core/oau_pkg.sv
// ----------------------------------------------------------------------------
// Operand address unit package
// Shared item, result and state types and the result kind codes.
// ----------------------------------------------------------------------------
package oau_pkg;

    localparam int unsigned WordW = 16;

    typedef logic [WordW-1:0] word_t;

    // Result kinds
    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_ADDR = 2'd1;
    localparam logic [1:0] KIND_REG  = 2'd2;

    // Addressing modes that the decode names explicitly
    localparam logic [2:0] MODE_REG       = 3'd0;
    localparam logic [2:0] MODE_DEF       = 3'd1;
    localparam logic [2:0] MODE_AUTOINC   = 3'd2;
    localparam logic [2:0] MODE_AUTOINC_D = 3'd3;
    localparam logic [2:0] MODE_AUTODEC   = 3'd4;
    localparam logic [2:0] MODE_AUTODEC_D = 3'd5;
    localparam logic [2:0] MODE_INDEX     = 3'd6;
    localparam logic [2:0] MODE_INDEX_D   = 3'd7;

    localparam logic [2:0] REG_PC = 3'd7;

    localparam logic CMD_SPEC = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FIRST = 2'd1,
        PH_DEFER = 2'd2
    } phase_t;

    typedef struct packed {
        logic       cmd;
        logic       byte_mode;
        logic [2:0] mode;
        logic [2:0] reg_num;
        word_t      reg_value;
        word_t      pc_value;
        word_t      read_data;
    } oau_item_t;

    typedef struct packed {
        logic [1:0] kind;
        word_t      address;
        logic [2:0] operand_reg;
        logic       reg_write;
        word_t      reg_new_value;
        logic       pc_write;
        word_t      pc_new_value;
        logic       protocol_error;
    } oau_result_t;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] pending_mode;
        word_t      pending_base;
    } oau_state_t;

endpackage

// File: rtl/core/oau_eval.sv
// ----------------------------------------------------------------------------
// Operand address evaluation
// Decodes one item against the pending-read state and forms its result
// and the next state. Purely combinational.
// ----------------------------------------------------------------------------
module oau_eval
    import oau_pkg::*;
(
    input  oau_item_t   item,
    input  oau_state_t  cur,
    output oau_state_t  nxt,
    output oau_result_t res
);

    word_t step;
    word_t pc_next;
    word_t data_sum;
    logic  pc_special;

    assign step       = item.byte_mode ? word_t'(1) : word_t'(2);
    assign pc_next    = item.pc_value + word_t'(2);
    assign data_sum   = item.read_data + cur.pending_base;
    assign pc_special = (item.reg_num == REG_PC) &&
                        ((item.mode == MODE_AUTOINC) || (item.mode == MODE_AUTOINC_D) ||
                         (item.mode == MODE_INDEX) || (item.mode == MODE_INDEX_D));

    always_comb
    begin
        res = '0;
        nxt = cur;
        if (item.cmd == CMD_DATA)
        begin
            priority if (cur.phase == PH_FIRST)
            begin
                res.address = data_sum;
                if (cur.pending_mode == MODE_INDEX_D)
                begin
                    res.kind  = KIND_READ;
                    nxt.phase = PH_DEFER;
                end
                else
                begin
                    res.kind  = KIND_ADDR;
                    nxt.phase = PH_IDLE;
                end
            end
            else if (cur.phase == PH_DEFER)
            begin
                res.kind    = KIND_ADDR;
                res.address = item.read_data;
                nxt.phase   = PH_IDLE;
            end
            else
            begin
                res.protocol_error = 1'b1;
            end
        end
        else if (cur.phase != PH_IDLE)
        begin
            // drop the specifier, keep the read outstanding
            res.protocol_error = 1'b1;
        end
        else if (pc_special)
        begin
            res.pc_write     = 1'b1;
            res.pc_new_value = pc_next;
            if (item.mode == MODE_AUTOINC)
            begin
                res.kind    = KIND_ADDR;
                res.address = pc_next + word_t'(item.byte_mode);
            end
            else
            begin
                res.kind         = KIND_READ;
                res.address      = pc_next;
                nxt.phase        = PH_FIRST;
                nxt.pending_mode = item.mode;
                nxt.pending_base = (item.mode == MODE_AUTOINC_D) ? '0
                                                                 : pc_next + word_t'(2);
            end
        end
        else
        begin
            unique case (item.mode)
                MODE_REG:
                begin
                    res.kind        = KIND_REG;
                    res.operand_reg = item.reg_num;
                end
                MODE_DEF:
                begin
                    res.kind    = KIND_ADDR;
                    res.address = item.reg_value;
                end
                MODE_AUTOINC:
                begin
                    res.kind          = KIND_ADDR;
                    res.address       = item.reg_value;
                    res.reg_write     = 1'b1;
                    res.reg_new_value = item.reg_value + step;
                end
                MODE_AUTOINC_D:
                begin
                    res.kind          = KIND_READ;
                    res.address       = item.reg_value;
                    res.reg_write     = 1'b1;
                    res.reg_new_value = item.reg_value + word_t'(2);
                    nxt.phase         = PH_FIRST;
                    nxt.pending_mode  = item.mode;
                    nxt.pending_base  = '0;
                end
                MODE_AUTODEC:
                begin
                    res.kind          = KIND_ADDR;
                    res.address       = item.reg_value - step;
                    res.reg_write     = 1'b1;
                    res.reg_new_value = item.reg_value - step;
                end
                MODE_AUTODEC_D:
                begin
                    res.kind          = KIND_READ;
                    res.address       = item.reg_value - word_t'(2);
                    res.reg_write     = 1'b1;
                    res.reg_new_value = item.reg_value - word_t'(2);
                    nxt.phase         = PH_FIRST;
                    nxt.pending_mode  = item.mode;
                    nxt.pending_base  = '0;
                end
                default:
                begin
                    // index and index deferred: fetch the extension word
                    res.kind         = KIND_READ;
                    res.address      = pc_next;
                    res.pc_write     = 1'b1;
                    res.pc_new_value = pc_next;
                    nxt.phase        = PH_FIRST;
                    nxt.pending_mode = item.mode;
                    nxt.pending_base = item.reg_value;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/operand_address_unit.sv
// ----------------------------------------------------------------------------
// Operand address unit
// Effective-address calculation for a six-bit operand specifier, with
// read requests for deferred, index and PC modes and register write-backs.
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload
//  -------  --------------------  ------------------------------------------
//  in       in_valid / in_stall   cmd byte_mode mode reg_num reg_value
//                                 pc_value read_data
//  out      out_valid / out_stall kind address operand_reg reg_write
//                                 reg_new_value pc_write pc_new_value
//                                 protocol_error
//
//  Each item gives exactly one result: it is held in the input register,
//  then the decode and its 16-bit adds settle into the result register.
//  One item per cycle is sustained while out is not stalled.
//  rst_n (asynchronous) empties both registers and returns the phase to idle.
//  A stall on out holds the result register; the input register then holds
//  too, and in_stall rises only while the input register is full and stuck.
//
module operand_address_unit
    import oau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic        byte_mode,
    input  logic [2:0]  mode,
    input  logic [2:0]  reg_num,
    input  logic [15:0] reg_value,
    input  logic [15:0] pc_value,
    input  logic [15:0] read_data,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [15:0] address,
    output logic [2:0]  operand_reg,
    output logic        reg_write,
    output logic [15:0] reg_new_value,
    output logic        pc_write,
    output logic [15:0] pc_new_value,
    output logic        protocol_error
);

    oau_item_t   item_reg;
    logic        item_valid_reg;
    oau_result_t res_reg;
    logic        res_valid_reg;
    oau_state_t  state_reg;

    oau_state_t  state_next;
    oau_result_t res_next;
    logic        advance;
    logic        take_in;

    // Move the held item into the result register whenever that slot is
    // free or being emptied this cycle.
    assign advance  = !res_valid_reg || !out_stall;
    assign in_stall = item_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    oau_eval u_eval (
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Control: occupancy of both registers and the pending-read state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= '{phase: PH_IDLE, pending_mode: '0, pending_base: '0};
        end
        else
        begin
            if (advance)
            begin
                res_valid_reg <= item_valid_reg;
            end
            if (take_in)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            // Advance the state only as its item commits to the result.
            if (item_valid_reg && advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload: hold while stalled.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg <= '{cmd: cmd, byte_mode: byte_mode, mode: mode,
                          reg_num: reg_num, reg_value: reg_value,
                          pc_value: pc_value, read_data: read_data};
        end
        if (item_valid_reg && advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = res_valid_reg;
    assign kind           = res_reg.kind;
    assign address        = res_reg.address;
    assign operand_reg    = res_reg.operand_reg;
    assign reg_write      = res_reg.reg_write;
    assign reg_new_value  = res_reg.reg_new_value;
    assign pc_write       = res_reg.pc_write;
    assign pc_new_value   = res_reg.pc_new_value;
    assign protocol_error = res_reg.protocol_error;

endmodule

// File: tb/operand_address_unit_test.sv
// ----------------------------------------------------------------------------
// Operand address unit regression
// Drives operand specifiers and returned read data through the valid/stall
// channels. Predicts each result from a private copy of the addressing state,
// then checks every result field in order. Sender and receiver idle at random.
// ----------------------------------------------------------------------------
module operand_address_unit_test;

    import oau_pkg::*;

    // Generous bound on the length of a correct run.
    localparam int CycleLimit  = 200000;
    localparam int RandomItems = 2000;

    typedef struct packed {
        logic      drain;   // hold this item until every result is back
        oau_item_t item;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = 1'b0;
    logic        byte_mode = 1'b0;
    logic [2:0]  mode = '0;
    logic [2:0]  reg_num = '0;
    logic [15:0] reg_value = '0;
    logic [15:0] pc_value = '0;
    logic [15:0] read_data = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [2:0]  operand_reg;
    logic        reg_write;
    logic [15:0] reg_new_value;
    logic        pc_write;
    logic [15:0] pc_new_value;
    logic        protocol_error;

    // Stimulus waiting to be driven, and results owed by the block.
    stim_t       specifier_stream[$];
    oau_result_t address_results_due[$];

    // Private copy of the addressing state.
    phase_t      ea_phase = PH_IDLE;
    logic [2:0]  ea_mode = '0;
    word_t       ea_base = '0;

    int          total_items = 0;
    int          items_sent = 0;
    int          items_accepted = 0;
    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct;
    int          recv_idle_pct;

    stim_t       next_stim;
    oau_item_t   on_bus;
    oau_result_t due;

    operand_address_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .byte_mode      (byte_mode),
        .mode           (mode),
        .reg_num        (reg_num),
        .reg_value      (reg_value),
        .pc_value       (pc_value),
        .read_data      (read_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .address        (address),
        .operand_reg    (operand_reg),
        .reg_write      (reg_write),
        .reg_new_value  (reg_new_value),
        .pc_write       (pc_write),
        .pc_new_value   (pc_new_value),
        .protocol_error (protocol_error)
    );

    assign on_bus = {cmd, byte_mode, mode, reg_num, reg_value, pc_value, read_data};

    // Idle schedule by progress through the stimulus: receiver-light first,
    // then sender-light, then full rate on both sides.
    assign send_idle_pct = (items_sent < total_items / 3)     ? 36 :
                           (items_sent < 2 * total_items / 3) ? 70 : 0;
    assign recv_idle_pct = (items_sent < total_items / 3)     ? 70 :
                           (items_sent < 2 * total_items / 3) ? 36 : 0;

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction: resolve one accepted item against the tracked state and
    // advance that state. Every item yields exactly one result.
    // ------------------------------------------------------------------------
    function automatic oau_result_t resolve_operand(input oau_item_t it);
        oau_result_t res;
        word_t       step;
        word_t       pc_next;
        word_t       sum;
        res     = '0;
        step    = it.byte_mode ? 16'd1 : 16'd2;
        pc_next = it.pc_value + 16'd2;
        sum     = it.read_data + ea_base;
        if (it.cmd == CMD_DATA) begin
            case (ea_phase)
                PH_FIRST:
                begin
                    res.address = sum;
                    // Index deferred needs a second read at the indexed address.
                    if (ea_mode == MODE_INDEX_D) begin
                        res.kind = KIND_READ;
                        ea_phase = PH_DEFER;
                    end else begin
                        res.kind = KIND_ADDR;
                        ea_phase = PH_IDLE;
                    end
                end
                PH_DEFER:
                begin
                    res.kind    = KIND_ADDR;
                    res.address = it.read_data;
                    ea_phase    = PH_IDLE;
                end
                default:
                    res.protocol_error = 1'b1;
            endcase
        end else if (ea_phase != PH_IDLE) begin
            // Drop a specifier that arrives while a read is outstanding.
            res.protocol_error = 1'b1;
        end else if (it.reg_num == REG_PC && it.mode inside
                     {MODE_AUTOINC, MODE_AUTOINC_D, MODE_INDEX, MODE_INDEX_D}) begin
            // PC modes: immediate, absolute, relative, relative deferred.
            res.pc_write     = 1'b1;
            res.pc_new_value = pc_next;
            if (it.mode == MODE_AUTOINC) begin
                res.kind    = KIND_ADDR;
                res.address = pc_next + {15'd0, it.byte_mode};
            end else begin
                res.kind    = KIND_READ;
                res.address = pc_next;
                ea_phase    = PH_FIRST;
                ea_mode     = it.mode;
                ea_base     = (it.mode == MODE_AUTOINC_D) ? 16'd0 : pc_next + 16'd2;
            end
        end else begin
            case (it.mode)
                MODE_REG:
                begin
                    res.kind        = KIND_REG;
                    res.operand_reg = it.reg_num;
                end
                MODE_DEF:
                begin
                    res.kind    = KIND_ADDR;
                    res.address = it.reg_value;
                end
                MODE_AUTOINC:
                begin
                    res.kind          = KIND_ADDR;
                    res.address       = it.reg_value;
                    res.reg_write     = 1'b1;
                    res.reg_new_value = it.reg_value + step;
                end
                MODE_AUTOINC_D:
                begin
                    res.kind          = KIND_READ;
                    res.address       = it.reg_value;
                    res.reg_write     = 1'b1;
                    res.reg_new_value = it.reg_value + 16'd2;
                    ea_phase          = PH_FIRST;
                    ea_mode           = it.mode;
                    ea_base           = '0;
                end
                MODE_AUTODEC:
                begin
                    res.kind          = KIND_ADDR;
                    res.address       = it.reg_value - step;
                    res.reg_write     = 1'b1;
                    res.reg_new_value = it.reg_value - step;
                end
                MODE_AUTODEC_D:
                begin
                    res.kind          = KIND_READ;
                    res.address       = it.reg_value - 16'd2;
                    res.reg_write     = 1'b1;
                    res.reg_new_value = it.reg_value - 16'd2;
                    ea_phase          = PH_FIRST;
                    ea_mode           = it.mode;
                    ea_base           = '0;
                end
                default:
                begin
                    // Index and index deferred: fetch the index word after the PC.
                    res.kind         = KIND_READ;
                    res.address      = pc_next;
                    res.pc_write     = 1'b1;
                    res.pc_new_value = pc_next;
                    ea_phase         = PH_FIRST;
                    ea_mode          = it.mode;
                    ea_base          = it.reg_value;
                end
            endcase
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Favor the wrap points, otherwise any word.
    function automatic word_t pick_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'hFFFE;
            default: return word_t'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic oau_item_t specifier(input logic bm, input logic [2:0] md,
                                            input logic [2:0] rn, input word_t r,
                                            input word_t p);
        oau_item_t it;
        it.cmd       = CMD_SPEC;
        it.byte_mode = bm;
        it.mode      = md;
        it.reg_num   = rn;
        it.reg_value = r;
        it.pc_value  = p;
        it.read_data = word_t'($urandom_range(16'hFFFF));
        return it;
    endfunction

    // Returned read data; the unused fields carry noise.
    function automatic oau_item_t read_return(input word_t d);
        oau_item_t it;
        it           = oau_item_t'({$urandom, $urandom});
        it.cmd       = CMD_DATA;
        it.read_data = d;
        return it;
    endfunction

    task automatic queue_item(input oau_item_t it, input logic drain);
        specifier_stream.push_back({drain, it});
    endtask

    // ------------------------------------------------------------------------
    // Driver: predict at acceptance, then advance to the next item or idle.
    // A stalled item holds its payload.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            ea_phase  = PH_IDLE;
            ea_mode   = '0;
            ea_base   = '0;
        end else begin
            if (in_valid && !in_stall) begin
                address_results_due.push_back(resolve_operand(on_bus));
                items_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (specifier_stream.size() != 0
                    && !(specifier_stream[0].drain && address_results_due.size() != 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                    next_stim = specifier_stream.pop_front();
                    {cmd, byte_mode, mode, reg_num, reg_value, pc_value, read_data}
                        <= next_stim.item;
                    in_valid <= 1'b1;
                    items_sent++;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted result against the oldest prediction,
    // then pick the stall for the next cycle.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $error("%s: expected 'h%0h, got 'h%0h", name, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (address_results_due.size() == 0) begin
                    errors++;
                    $error("result with none outstanding: kind %0d address 'h%0h",
                           kind, address);
                end else begin
                    due = address_results_due.pop_front();
                    check_field("kind", 16'(due.kind), 16'(kind));
                    check_field("address", due.address, address);
                    check_field("operand_reg", 16'(due.operand_reg), 16'(operand_reg));
                    check_field("reg_write", 16'(due.reg_write), 16'(reg_write));
                    check_field("reg_new_value", due.reg_new_value, reg_new_value);
                    check_field("pc_write", 16'(due.pc_write), 16'(pc_write));
                    check_field("pc_new_value", due.pc_new_value, pc_new_value);
                    check_field("protocol_error", 16'(due.protocol_error),
                                16'(protocol_error));
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("operand_address_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int        counted;
        int        reads_owed;
        logic [2:0] md;
        logic [2:0] rn;

        // Directed: data while idle, then each mode at its wrap points.
        queue_item(read_return(16'hFFFF), 1'b0);
        queue_item(specifier(1'b0, MODE_REG, 3'd0, 16'h0000, 16'h0000), 1'b0);
        queue_item(specifier(1'b1, MODE_REG, REG_PC, 16'hFFFF, 16'hFFFF), 1'b0);
        queue_item(specifier(1'b0, MODE_DEF, 3'd3, 16'hFFFF, 16'h0000), 1'b0);
        queue_item(specifier(1'b1, MODE_AUTOINC, 3'd1, 16'hFFFF, 16'h1234), 1'b0);
        queue_item(specifier(1'b0, MODE_AUTOINC, 3'd2, 16'hFFFE, 16'h0000), 1'b0);
        queue_item(specifier(1'b0, MODE_AUTODEC, 3'd4, 16'h0001, 16'h0000), 1'b0);
        // PC as an ordinary register in autodecrement
        queue_item(specifier(1'b1, MODE_AUTODEC, REG_PC, 16'h0000, 16'h5555), 1'b0);
        queue_item(specifier(1'b0, MODE_AUTOINC_D, 3'd5, 16'hFFFF, 16'h0000), 1'b0);
        queue_item(read_return(16'h1234), 1'b0);
        queue_item(specifier(1'b1, MODE_AUTODEC_D, REG_PC, 16'h0001, 16'hAAAA), 1'b0);
        // Specifier while a read is outstanding
        queue_item(specifier(1'b0, MODE_REG, 3'd0, 16'h0000, 16'h0000), 1'b0);
        queue_item(read_return(16'h0000), 1'b0);
        queue_item(specifier(1'b0, MODE_INDEX, 3'd6, 16'hFFFF, 16'hFFFE), 1'b0);
        queue_item(read_return(16'h0002), 1'b0);
        queue_item(specifier(1'b1, MODE_INDEX_D, 3'd2, 16'h8000, 16'h1234), 1'b0);
        queue_item(read_return(16'h8000), 1'b0);
        queue_item(read_return(16'hABCD), 1'b0);
        // PC immediate, absolute, relative, relative deferred
        queue_item(specifier(1'b1, MODE_AUTOINC, REG_PC, 16'h0000, 16'hFFFE), 1'b0);
        queue_item(specifier(1'b0, MODE_AUTOINC, REG_PC, 16'h0000, 16'h0100), 1'b0);
        queue_item(specifier(1'b0, MODE_AUTOINC_D, REG_PC, 16'h0000, 16'hFFFF), 1'b0);
        queue_item(read_return(16'h2000), 1'b0);
        queue_item(specifier(1'b0, MODE_INDEX, REG_PC, 16'h0000, 16'hFFFC), 1'b0);
        queue_item(read_return(16'hFFFF), 1'b0);
        queue_item(specifier(1'b1, MODE_INDEX_D, REG_PC, 16'hFFFF, 16'h1000), 1'b0);
        queue_item(read_return(16'h0010), 1'b0);
        queue_item(read_return(16'hFFFF), 1'b0);

        // Random: mostly complete specifier/read sequences, some noise and
        // some sequences cut short. Drain the pipeline now and then.
        counted = 0;
        while (counted < RandomItems) begin
            if ($urandom_range(9) == 0) begin
                queue_item(oau_item_t'({$urandom, $urandom}), 1'b0);
            end else begin
                md = 3'($urandom_range(7));
                rn = ($urandom_range(3) == 0) ? REG_PC : 3'($urandom_range(7));
                queue_item(specifier(1'($urandom_range(1)), md, rn, pick_word(),
                                     pick_word()),
                           (counted % 700) == 0);
                counted++;
                reads_owed = (md == MODE_INDEX_D) ? 2 :
                             (md inside {MODE_AUTOINC_D, MODE_AUTODEC_D, MODE_INDEX}) ? 1 : 0;
                if (reads_owed > 0 && $urandom_range(15) == 0)
                    reads_owed--;
                repeat (reads_owed) begin
                    queue_item(read_return(pick_word()), 1'b0);
                    counted++;
                end
            end
        end
        total_items = specifier_stream.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to be taken and every result to come back.
        while (items_accepted < total_items)
            @(posedge clk);
        while (address_results_due.size() != 0)
            @(posedge clk);
        // Catch any stray result behind the last one.
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("operand_address_unit regression: pass");
        else
            $display("operand_address_unit regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/oau_pkg.sv
rtl/core/oau_eval.sv
rtl/core/operand_address_unit.sv
tb/operand_address_unit_test.sv
